@@ hw/rtl/bidirectional_occupancy_counter_core_defines.svh @@
// assertion macros shared by the occupancy counter rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef BIDIRECTIONAL_OCCUPANCY_COUNTER_CORE_DEFINES_SVH
`define BIDIRECTIONAL_OCCUPANCY_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BOC_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BOC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/boc_pkg.sv @@
// shared types and constants for the occupancy counter
// no dependencies; used by every module of the block
package boc_pkg;

    // field widths
    localparam int DIST_W   = 12;
    localparam int OCC_W    = 16;
    localparam int EVENT_W  = 2;
    localparam int CFG_W    = 8;
    localparam int STAMP_W  = 16;
    localparam int ADDR_W   = 2;

    // parameter defaults
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 16;

    // echo width to centimetres: (ticks * SOUND_SCALE) >> SCALE_SHIFT
    localparam int SOUND_SCALE = 34300;
    localparam int SCALE_SHIFT = 20;
    localparam int DIST_MAX    = 4095;

    // register reset values
    localparam logic [CFG_W-1:0] NEAR_LIMIT_RST = 8'd8;
    localparam logic [CFG_W-1:0] EXPIRY_RST     = 8'd50;
    localparam logic [CFG_W-1:0] WRAP_RST       = 8'd100;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_NEAR_LIMIT = 2'd0;
    localparam logic [ADDR_W-1:0] REG_EXPIRY     = 2'd1;
    localparam logic [ADDR_W-1:0] REG_WRAP       = 2'd2;

    // crossing event codes
    localparam logic [EVENT_W-1:0] EVT_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EVT_ENTER = 2'd1;
    localparam logic [EVENT_W-1:0] EVT_LEAVE = 2'd2;

    // sensor codes
    localparam logic SENSOR_A = 1'b0;
    localparam logic SENSOR_B = 1'b1;

    typedef struct packed {
        logic               sensor_select;
        logic [STAMP_W-1:0] edge_time;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] near_limit_cm;
        logic [CFG_W-1:0] pending_expiry;
        logic [CFG_W-1:0] counter_wrap;
    } cfg_t;

    typedef struct packed {
        logic               measurement_done;
        logic [DIST_W-1:0]  distance_cm;
        logic [EVENT_W-1:0] crossing_event;
        logic [OCC_W-1:0]   occupancy;
    } result_t;

endpackage

@@ hw/rtl/bidirectional_occupancy_counter_core.sv @@
// occupancy counter top: 1 item per cycle; each item passes the input register, then the tracker
// logic into the result register; stalls only on m_tready
// aresetn is synchronous active low: clears pipeline valids, all tracker state and
// loads the register defaults (near 8, expiry 50, wrap 100)
// depends on boc_pkg, boc_tracker
module bidirectional_occupancy_counter_core #(
    parameter int COUNT_WIDTH = boc_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = boc_pkg::TIME_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration writes
    input  logic                         cfg_wr_en,
    input  logic [boc_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [boc_pkg::CFG_W-1:0]    cfg_wr_data,
    // input channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] edge_time
    input  logic                         s_tuser,   // [0] sensor_select
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [11:0] distance_cm, [13:12] crossing_event,
                                                    // [29:14] occupancy, [31:30] zero
    output logic                         m_tuser    // [0] measurement_done
);

    boc_pkg::cfg_t    cfg_reg;
    boc_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    boc_pkg::result_t res;
    boc_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_limit_cm  <= boc_pkg::NEAR_LIMIT_RST;
            cfg_reg.pending_expiry <= boc_pkg::EXPIRY_RST;
            cfg_reg.counter_wrap   <= boc_pkg::WRAP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                boc_pkg::REG_NEAR_LIMIT: cfg_reg.near_limit_cm  <= cfg_wr_data;
                boc_pkg::REG_EXPIRY:     cfg_reg.pending_expiry <= cfg_wr_data;
                boc_pkg::REG_WRAP:       cfg_reg.counter_wrap   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // pipeline flow
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.sensor_select <= s_tuser;
            in_item_reg.edge_time     <= s_tdata;
        end
    end

    boc_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.measurement_done;
    assign m_tdata  = {2'b00, out_reg.occupancy, out_reg.crossing_event, out_reg.distance_cm};

endmodule

@@ hw/rtl/boc_pulse_meter.sv @@
// echo pulse width to distance in centimetres, saturated to 12 bits
// depends on boc_pkg
module boc_pulse_meter #(
    parameter int TIME_WIDTH = boc_pkg::TIME_WIDTH_DEF
) (
    input  logic [TIME_WIDTH-1:0]     rise_stamp,
    input  logic [TIME_WIDTH-1:0]     fall_stamp,
    output logic [boc_pkg::DIST_W-1:0] distance_cm
);

    localparam int PROD_W = TIME_WIDTH + 16;
    localparam int QUOT_W = PROD_W - boc_pkg::SCALE_SHIFT;
    localparam int EXT_W  = QUOT_W + boc_pkg::DIST_W;

    logic [TIME_WIDTH-1:0] ticks;
    logic [PROD_W-1:0]     product;
    logic [QUOT_W-1:0]     quot;
    logic [EXT_W-1:0]      quot_ext;

    // modular width, constant multiply, fixed shift
    assign ticks    = fall_stamp - rise_stamp;
    assign product  = {16'b0, ticks} * PROD_W'(boc_pkg::SOUND_SCALE);
    assign quot     = product[PROD_W-1:boc_pkg::SCALE_SHIFT];
    assign quot_ext = {{boc_pkg::DIST_W{1'b0}}, quot};

    // clamp to the field range
    assign distance_cm = (quot_ext > EXT_W'(boc_pkg::DIST_MAX)) ?
                         boc_pkg::DIST_W'(boc_pkg::DIST_MAX) : quot_ext[boc_pkg::DIST_W-1:0];

endmodule

@@ hw/rtl/boc_tracker.sv @@
// per-sensor edge pairing, direction arming, expiry counters and occupancy
// depends on boc_pkg, boc_pulse_meter and the assertion macro header
`include "bidirectional_occupancy_counter_core_defines.svh"

module boc_tracker #(
    parameter int COUNT_WIDTH = boc_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = boc_pkg::TIME_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  boc_pkg::item_t   item,
    input  boc_pkg::cfg_t    cfg,
    output boc_pkg::result_t result
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [1:0]                 phase_reg;
    logic [TIME_WIDTH-1:0]      rise_reg [2];
    logic [boc_pkg::CFG_W-1:0]  meas_reg [2];
    logic                       entry_reg, entry_next;
    logic                       exit_reg, exit_next;
    logic [COUNT_WIDTH-1:0]     people_reg, people_next;
    logic [boc_pkg::CFG_W-1:0]  meas_next;

    logic                        sel;
    logic [TIME_WIDTH+15:0]      time_ext;
    logic [TIME_WIDTH-1:0]       stamp;
    logic [boc_pkg::DIST_W-1:0]  dist_cm;
    logic                        closing;
    logic                        near;
    logic                        complete;
    logic                        armed;
    logic [boc_pkg::CFG_W-1:0]   meas_base;
    logic [boc_pkg::CFG_W-1:0]   meas_inc;
    logic [boc_pkg::EVENT_W-1:0] event_code;
    logic [COUNT_WIDTH+15:0]     people_ext;

    // timer value reduced to the timer width
    assign sel      = item.sensor_select;
    assign time_ext = {{TIME_WIDTH{1'b0}}, item.edge_time};
    assign stamp    = time_ext[TIME_WIDTH-1:0];

    boc_pulse_meter #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_meter (
        .rise_stamp  (rise_reg[sel]),
        .fall_stamp  (stamp),
        .distance_cm (dist_cm)
    );

    assign closing  = phase_reg[sel];
    assign near     = (dist_cm != '0) &&
                      (dist_cm < {{(boc_pkg::DIST_W-boc_pkg::CFG_W){1'b0}}, cfg.near_limit_cm});
    assign complete = (sel == boc_pkg::SENSOR_A) ? entry_reg : exit_reg;

    // crossing decision and measurement counter
    always_comb begin
        entry_next  = entry_reg;
        exit_next   = exit_reg;
        people_next = people_reg;
        event_code  = boc_pkg::EVT_NONE;
        meas_base   = meas_reg[sel];
        if (closing && near) begin
            if (complete) begin
                entry_next = 1'b0;
                exit_next  = 1'b0;
                if (sel == boc_pkg::SENSOR_A) begin
                    event_code = boc_pkg::EVT_ENTER;
                    if (people_reg != COUNT_MAX) begin
                        people_next = people_reg + 1'b1;
                    end
                end else if (people_reg != '0) begin
                    event_code  = boc_pkg::EVT_LEAVE;
                    people_next = people_reg - 1'b1;
                end
            end else begin
                if (sel == boc_pkg::SENSOR_A) begin
                    exit_next = 1'b1;
                end else begin
                    entry_next = 1'b1;
                end
                meas_base = '0;
            end
        end
        meas_inc = meas_base + 1'b1;
        armed    = (sel == boc_pkg::SENSOR_A) ? exit_next : entry_next;
        if ((meas_inc == cfg.pending_expiry) && armed) begin
            meas_next = '0;
            if (sel == boc_pkg::SENSOR_A) begin
                exit_next = 1'b0;
            end else begin
                entry_next = 1'b0;
            end
        end else if (meas_inc == cfg.counter_wrap) begin
            meas_next = '0;
        end else begin
            meas_next = meas_inc;
        end
    end

    // result of this item
    assign people_ext = {16'b0, (closing ? people_next : people_reg)};
    always_comb begin
        result.measurement_done = closing;
        result.distance_cm      = closing ? dist_cm : '0;
        result.crossing_event   = closing ? event_code : boc_pkg::EVT_NONE;
        result.occupancy        = people_ext[boc_pkg::OCC_W-1:0];
    end

    // state update on each processed transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            rise_reg[0] <= '0;
            rise_reg[1] <= '0;
            meas_reg[0] <= '0;
            meas_reg[1] <= '0;
            entry_reg   <= 1'b0;
            exit_reg    <= 1'b0;
            people_reg  <= '0;
        end else if (advance) begin
            if (closing) begin
                phase_reg[sel] <= 1'b0;
                meas_reg[sel]  <= meas_next;
                entry_reg      <= entry_next;
                exit_reg       <= exit_next;
                people_reg     <= people_next;
            end else begin
                phase_reg[sel] <= 1'b1;
                rise_reg[sel]  <= stamp;
            end
        end
    end

    // checks
    `BOC_ASSERT_IMPLIES(a_flags_exclusive, aclk, aresetn, 1'b1, !(entry_reg && exit_reg), "both directions armed")
    `BOC_ASSERT_IMPLIES(a_event_needs_done, aclk, aresetn, advance, (result.crossing_event == boc_pkg::EVT_NONE) || result.measurement_done, "crossing without closed pulse")
    `BOC_ASSERT_NEXT(a_no_underflow, aclk, aresetn, advance && (people_reg == '0), people_reg <= COUNT_WIDTH'(1), "occupancy wrapped below zero")

endmodule
